[rtl/stl_pkg.sv]
// shared types, constants and keyword table for the script token lexer
package stl_pkg;

	localparam int POS_BITS = 20;
	localparam int KEYWORD_CHARS = 8;
	localparam int NUM_KEYWORDS = 18;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX = 2;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	typedef enum logic [3:0] {
		M_NORMAL, M_SLASH, M_BANG, M_EQ, M_GT, M_LT,
		M_NUMBER, M_WORD, M_STRING, M_LINE, M_BLOCK
	} mode_t;

	localparam logic [1:0] RK_TOKEN = 2'd0;
	localparam logic [1:0] RK_BAD_CHAR = 2'd1;
	localparam logic [1:0] RK_OPEN_STRING = 2'd2;

	localparam logic [5:0] TK_IDENT = 6'd0;
	localparam logic [5:0] TK_NUMBER = 6'd1;
	localparam logic [5:0] TK_STRING = 6'd2;
	localparam logic [5:0] TK_BINOP = 6'd3;
	localparam logic [5:0] TK_LOGICOP = 6'd4;
	localparam logic [5:0] TK_BANG = 6'd5;
	localparam logic [5:0] TK_EQUALS = 6'd6;
	localparam logic [5:0] TK_LPAREN = 6'd7;
	localparam logic [5:0] TK_RPAREN = 6'd8;
	localparam logic [5:0] TK_LBRACE = 6'd9;
	localparam logic [5:0] TK_RBRACE = 6'd10;
	localparam logic [5:0] TK_LBRACKET = 6'd11;
	localparam logic [5:0] TK_RBRACKET = 6'd12;
	localparam logic [5:0] TK_SEMI = 6'd13;
	localparam logic [5:0] TK_COLON = 6'd14;
	localparam logic [5:0] TK_COMMA = 6'd15;
	localparam logic [5:0] TK_DOT = 6'd16;
	localparam logic [5:0] TK_EOF = 6'd17;
	localparam logic [5:0] TK_KEYWORD0 = 6'd18;

	typedef struct packed {
		logic [1:0] record_kind;
		logic [5:0] token_kind;
		logic [POS_BITS-1:0] start_offset;
		logic [POS_BITS-1:0] token_length;
		logic [7:0] bad_char;
	} rec_t;

	// up to two records caused by one item
	typedef struct packed {
		logic [1:0] count;
		rec_t r2;
		rec_t r1;
		rec_t r0;
	} group_t;

	function automatic logic [63:0] kw_packed(input int i);
		case (i)
			0: kw_packed = 64'h6C6574;
			1: kw_packed = 64'h636F6E7374;
			2: kw_packed = 64'h7072696E74;
			3: kw_packed = 64'h746F67676C65;
			4: kw_packed = 64'h73706C6974;
			5: kw_packed = 64'h6C656E677468;
			6: kw_packed = 64'h72656164;
			7: kw_packed = 64'h7772697465;
			8: kw_packed = 64'h65786563;
			9: kw_packed = 64'h737061776E;
			10: kw_packed = 64'h6966;
			11: kw_packed = 64'h656C7365;
			12: kw_packed = 64'h7768696C65;
			13: kw_packed = 64'h666F72;
			14: kw_packed = 64'h66756E6374696F6E;
			15: kw_packed = 64'h72657475726E;
			16: kw_packed = 64'h627265616B;
			17: kw_packed = 64'h636F6E74696E7565;
			default: kw_packed = '0;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input int i);
		case (i)
			0, 13: kw_len = 4'd3;
			6, 8, 11: kw_len = 4'd4;
			1, 2, 4, 7, 9, 12, 16: kw_len = 4'd5;
			3, 5, 15: kw_len = 4'd6;
			10: kw_len = 4'd2;
			14, 17: kw_len = 4'd8;
			default: kw_len = 4'd0;
		endcase
	endfunction

endpackage

[rtl/stl_front.sv]
// front end: lexer state and classification of each item into a record group
module stl_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [7:0] source_byte,
	output logic grp_valid,
	input logic grp_ready,
	output stl_pkg::group_t grp
);
	import stl_pkg::*;

	mode_t mode_q, mode_d;
	logic star_q, star_d;
	logic [POS_BITS-1:0] pos_q, pos_d, start_q, start_d, len_q, len_d;
	logic [63:0] word_q, word_d;
	logic too_long_q, too_long_d;
	group_t g;
	logic [5:0] wkind;

	assign in_ready = grp_ready;
	assign grp_valid = in_valid;
	assign grp = g;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		sat_inc = (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic rec_t mk(input logic [1:0] rk, input logic [5:0] tk,
			input logic [POS_BITS-1:0] st, input logic [POS_BITS-1:0] ln,
			input logic [7:0] bc);
		rec_t r;
		r.record_kind = rk;
		r.token_kind = tk;
		r.start_offset = st;
		r.token_length = ln;
		r.bad_char = bc;
		mk = r;
	endfunction

	always_comb begin
		wkind = TK_IDENT;
		if (!too_long_q && len_q <= POS_BITS'(KEYWORD_CHARS)) begin
			for (int i = 0; i < NUM_KEYWORDS; i++) begin
				if (len_q == POS_BITS'(kw_len(i)) && word_q == kw_packed(i))
					wkind = TK_KEYWORD0 + 6'(i);
			end
		end
	end

	always_comb begin
		logic flush;
		logic start;
		logic is_dig, is_let, is_sp;
		rec_t fr;
		logic fv;
		rec_t sr;
		logic sv;
		logic [5:0] pk;
		flush = 1'b0;
		start = 1'b0;
		fv = 1'b0;
		fr = '0;
		sv = 1'b0;
		sr = '0;
		pk = '0;
		mode_d = mode_q;
		star_d = star_q;
		pos_d = pos_q;
		start_d = start_q;
		len_d = len_q;
		word_d = word_q;
		too_long_d = too_long_q;
		g = '0;
		is_dig = source_byte >= 8'h30 && source_byte <= 8'h39;
		is_let = (source_byte >= 8'h61 && source_byte <= 8'h7A) ||
			(source_byte >= 8'h41 && source_byte <= 8'h5A);
		is_sp = source_byte == 8'h20 || (source_byte >= 8'h09 && source_byte <= 8'h0D);
		if (kind) begin
			if (mode_q == M_STRING) begin
				fv = 1'b1;
				fr = mk(RK_OPEN_STRING, TK_STRING, start_q, len_q, 8'd0);
			end else if (mode_q != M_LINE && mode_q != M_BLOCK) begin
				flush = 1'b1;
			end
		end else begin
			pos_d = sat_inc(pos_q);
			case (mode_q)
				M_STRING: begin
					if (source_byte == 8'h22) begin
						fv = 1'b1;
						fr = mk(RK_TOKEN, TK_STRING, start_q, len_q, 8'd0);
						mode_d = M_NORMAL;
					end else
						len_d = sat_inc(len_q);
				end
				M_LINE: if (source_byte == 8'h0A) mode_d = M_NORMAL;
				M_BLOCK: begin
					if (star_q && source_byte == 8'h2F) begin
						mode_d = M_NORMAL;
						star_d = 1'b0;
					end else
						star_d = source_byte == 8'h2A;
				end
				M_NUMBER: begin
					if (is_dig) len_d = sat_inc(len_q);
					else begin flush = 1'b1; start = 1'b1; end
				end
				M_WORD: begin
					if (is_let) begin
						if (!too_long_q && len_q < POS_BITS'(KEYWORD_CHARS))
							word_d = {word_q[55:0], source_byte};
						else
							too_long_d = 1'b1;
						len_d = sat_inc(len_q);
					end else begin flush = 1'b1; start = 1'b1; end
				end
				M_SLASH: begin
					if (source_byte == 8'h2F) mode_d = M_LINE;
					else if (source_byte == 8'h2A) begin
						mode_d = M_BLOCK;
						star_d = 1'b0;
					end else begin flush = 1'b1; start = 1'b1; end
				end
				M_BANG, M_EQ, M_GT, M_LT: begin
					if (source_byte == 8'h3D) begin
						fv = 1'b1;
						fr = mk(RK_TOKEN, TK_LOGICOP, start_q, POS_BITS'(2), 8'd0);
						mode_d = M_NORMAL;
					end else begin flush = 1'b1; start = 1'b1; end
				end
				default: start = 1'b1;
			endcase
		end
		if (flush) begin
			mode_d = M_NORMAL;
			fv = 1'b1;
			case (mode_q)
				M_SLASH: fr = mk(RK_TOKEN, TK_BINOP, start_q, POS_BITS'(1), 8'd0);
				M_BANG: fr = mk(RK_TOKEN, TK_BANG, start_q, POS_BITS'(1), 8'd0);
				M_EQ: fr = mk(RK_TOKEN, TK_EQUALS, start_q, POS_BITS'(1), 8'd0);
				M_GT, M_LT: fr = mk(RK_TOKEN, TK_LOGICOP, start_q, POS_BITS'(1), 8'd0);
				M_NUMBER: fr = mk(RK_TOKEN, TK_NUMBER, start_q, len_q, 8'd0);
				M_WORD: fr = mk(RK_TOKEN, wkind, start_q, len_q, 8'd0);
				default: fv = 1'b0;
			endcase
		end
		if (start) begin
			mode_d = M_NORMAL;
			case (source_byte)
				8'h28: pk = TK_LPAREN;
				8'h29: pk = TK_RPAREN;
				8'h7B: pk = TK_LBRACE;
				8'h7D: pk = TK_RBRACE;
				8'h5B: pk = TK_LBRACKET;
				8'h5D: pk = TK_RBRACKET;
				8'h3B: pk = TK_SEMI;
				8'h3A: pk = TK_COLON;
				8'h2C: pk = TK_COMMA;
				8'h2E: pk = TK_DOT;
				8'h2B, 8'h2D, 8'h2A, 8'h25: pk = TK_BINOP;
				8'h2F: mode_d = M_SLASH;
				8'h21: mode_d = M_BANG;
				8'h3D: mode_d = M_EQ;
				8'h3E: mode_d = M_GT;
				8'h3C: mode_d = M_LT;
				8'h22: mode_d = M_STRING;
				default: ;
			endcase
			if (mode_d == M_STRING) begin
				start_d = sat_inc(pos_q);
				len_d = '0;
			end else if (pk != 6'd0) begin
				sv = 1'b1;
				sr = mk(RK_TOKEN, pk, pos_q, POS_BITS'(1), 8'd0);
			end else if (mode_d != M_NORMAL) begin
				start_d = pos_q;
				len_d = POS_BITS'(1);
			end else if (is_dig) begin
				mode_d = M_NUMBER;
				start_d = pos_q;
				len_d = POS_BITS'(1);
			end else if (is_let) begin
				mode_d = M_WORD;
				start_d = pos_q;
				len_d = POS_BITS'(1);
				word_d = {56'd0, source_byte};
				too_long_d = 1'b0;
			end else if (!is_sp) begin
				sv = 1'b1;
				sr = mk(RK_BAD_CHAR, TK_IDENT, pos_q, POS_BITS'(1), source_byte);
			end
		end
		if (kind) begin
			sv = 1'b1;
			sr = mk(RK_TOKEN, TK_EOF, pos_q, '0, 8'd0);
		end
		g.r0 = fv ? fr : sr;
		g.r1 = sr;
		g.count = 2'(fv) + 2'(sv);
		if (kind) begin
			mode_d = M_NORMAL;
			star_d = 1'b0;
			pos_d = '0;
			start_d = '0;
			len_d = '0;
			word_d = '0;
			too_long_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			star_q <= 1'b0;
			pos_q <= '0;
			start_q <= '0;
			len_q <= '0;
			word_q <= '0;
			too_long_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			mode_q <= mode_d;
			star_q <= star_d;
			pos_q <= pos_d;
			start_q <= start_d;
			len_q <= len_d;
			word_q <= word_d;
			too_long_q <= too_long_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> mode_q == M_NORMAL && pos_q == '0)
		else $error("end of source did not return to reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && kind |-> grp.count != 2'd0)
		else $error("end of source without eof record");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> grp.count != 2'd3)
		else $error("more than two records for one request");

endmodule

[rtl/stl_queue.sv]
// short queue of record groups between front and back
module stl_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input stl_pkg::group_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output stl_pkg::group_t rd_data
);
	import stl_pkg::*;

	group_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_IDX-1:0] wp_q, rp_q;
	logic [QUEUE_IDX:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (QUEUE_IDX+1)'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready && wr_data.count != 2'd0;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_IDX+1)'(wr) - (QUEUE_IDX+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_IDX+1)'(QUEUE_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid |-> rd_data.count != 2'd0)
		else $error("empty group queued");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wp_q == rp_q)
		else $error("pointers disagree with count");

endmodule

[rtl/stl_back.sv]
// back end: serializes each record group onto the output channel
module stl_back (
	input logic clk,
	input logic arst_n,
	input logic grp_valid,
	output logic grp_ready,
	input stl_pkg::group_t grp,
	output logic out_valid,
	input logic out_ready,
	output stl_pkg::rec_t rec,
	output logic rec_last
);
	import stl_pkg::*;

	logic idx_q;
	logic fire;

	assign out_valid = grp_valid;
	assign rec = idx_q ? grp.r1 : grp.r0;
	assign rec_last = idx_q || grp.count == 2'd1;
	assign fire = out_valid && out_ready;
	assign grp_ready = fire && rec_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= 1'b0;
		else if (fire) idx_q <= !rec_last;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> grp_valid && grp.count == 2'd2)
		else $error("second record without pair");
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !rec_last |=> idx_q)
		else $error("record index did not advance");
	assert property (@(posedge clk) disable iff (!arst_n)
		grp_ready |-> rec_last)
		else $error("group released early");

endmodule

[rtl/script_token_lexer.sv]
// top level of the streaming script token lexer
//
// input channel: kind, source_byte with in_valid / in_ready; one request is
// one source byte or an end-of-source mark
// output channel: zero to two token or error records per request on out_valid /
// out_ready, with last set on the final record caused by an input request
// throughput: one input byte per cycle while the queue has room; a byte that
// yields two records is absorbed by a four-entry group queue
// record groups are registered in the group queue between front and back end
// the front lexer state updates as each request is accepted; the back end
// drains queued record groups one record per cycle while out_ready is high
// end of source flushes the pending token (or reports an open string), emits eof and returns to reset
// reset clears lexer state and empties the queue
// when the receiver stalls the queue fills and in_ready drops once full
module script_token_lexer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [7:0] source_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] record_kind,
	output logic [5:0] token_kind,
	output logic [19:0] start_offset,
	output logic [19:0] token_length,
	output logic [7:0] bad_char,
	output logic last
);
	import stl_pkg::*;

	group_t fg, qg;
	rec_t rec;
	logic f_valid, f_ready, q_valid, q_ready;

	stl_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .kind, .source_byte,
		.grp_valid(f_valid), .grp_ready(f_ready), .grp(fg)
	);

	stl_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(fg),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qg)
	);

	stl_back u_back (
		.clk, .arst_n, .grp_valid(q_valid), .grp_ready(q_ready), .grp(qg),
		.out_valid, .out_ready, .rec, .rec_last(last)
	);

	assign record_kind = rec.record_kind;
	assign token_kind = rec.token_kind;
	assign start_offset = rec.start_offset;
	assign token_length = rec.token_length;
	assign bad_char = rec.bad_char;

endmodule

[tb/script_token_lexer_tb.sv]
// self-checking testbench for the script token lexer: directed and random byte streams
module script_token_lexer_tb;
	import stl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic IN_BYTE = 1'b0;
	localparam logic IN_END = 1'b1;

	typedef struct packed {
		logic [1:0] rk;
		logic [5:0] tk;
		logic [19:0] st;
		logic [19:0] ln;
		logic [7:0] bc;
		logic lst;
	} token_rec_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [7:0] source_byte;
	logic out_valid;
	logic out_ready;
	logic [1:0] record_kind;
	logic [5:0] token_kind;
	logic [19:0] start_offset;
	logic [19:0] token_length;
	logic [7:0] bad_char;
	logic last;

	script_token_lexer uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .source_byte(source_byte), .out_valid(out_valid),
		.out_ready(out_ready), .record_kind(record_kind), .token_kind(token_kind),
		.start_offset(start_offset), .token_length(token_length),
		.bad_char(bad_char), .last(last)
	);

	token_rec_t expected_tokens[$];
	int fail_count = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	int records_seen = 0;
	bit hold_off = 1'b0;

	mode_t lx_mode;
	logic lx_star;
	logic [19:0] lx_pos;
	logic [19:0] lx_start;
	logic [19:0] lx_len;
	logic [63:0] lx_word;
	logic lx_long;
	token_rec_t new_recs[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** script_token_lexer: FAILED **");
			$finish;
		end
	end

	function automatic logic [19:0] sat_up(logic [19:0] v);
		return (v == POS_MAX) ? v : v + 20'd1;
	endfunction

	function automatic bit digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit space_c(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	task automatic add_rec(logic [1:0] rk, logic [5:0] tk, logic [19:0] st,
			logic [19:0] ln, logic [7:0] bc);
		token_rec_t r;
		r = '{rk, tk, st, ln, bc, 1'b0};
		new_recs.insert(new_recs.size(), r);
	endtask

	function automatic logic [5:0] word_token();
		logic [63:0] w;
		logic [3:0] n;
		if (lx_long || lx_len > KEYWORD_CHARS) return TK_IDENT;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			case (i)
				0: begin w = "let"; n = 4'd3; end
				1: begin w = "const"; n = 4'd5; end
				2: begin w = "print"; n = 4'd5; end
				3: begin w = "toggle"; n = 4'd6; end
				4: begin w = "split"; n = 4'd5; end
				5: begin w = "length"; n = 4'd6; end
				6: begin w = "read"; n = 4'd4; end
				7: begin w = "write"; n = 4'd5; end
				8: begin w = "exec"; n = 4'd4; end
				9: begin w = "spawn"; n = 4'd5; end
				10: begin w = "if"; n = 4'd2; end
				11: begin w = "else"; n = 4'd4; end
				12: begin w = "while"; n = 4'd5; end
				13: begin w = "for"; n = 4'd3; end
				14: begin w = "function"; n = 4'd8; end
				15: begin w = "return"; n = 4'd6; end
				16: begin w = "break"; n = 4'd5; end
				default: begin w = "continue"; n = 4'd8; end
			endcase
			if (lx_len == 20'(n) && w == lx_word) return TK_KEYWORD0 + 6'(i);
		end
		return TK_IDENT;
	endfunction

	task automatic flush_token();
		case (lx_mode)
			M_SLASH: add_rec(RK_TOKEN, TK_BINOP, lx_start, 20'd1, 8'd0);
			M_BANG: add_rec(RK_TOKEN, TK_BANG, lx_start, 20'd1, 8'd0);
			M_EQ: add_rec(RK_TOKEN, TK_EQUALS, lx_start, 20'd1, 8'd0);
			M_GT, M_LT: add_rec(RK_TOKEN, TK_LOGICOP, lx_start, 20'd1, 8'd0);
			M_NUMBER: add_rec(RK_TOKEN, TK_NUMBER, lx_start, lx_len, 8'd0);
			M_WORD: add_rec(RK_TOKEN, word_token(), lx_start, lx_len, 8'd0);
			default: ;
		endcase
		lx_mode = M_NORMAL;
	endtask

	task automatic begin_char(logic [7:0] c, logic [19:0] pos);
		logic [5:0] pk;
		pk = '0;
		lx_mode = M_NORMAL;
		case (c)
			"(": pk = TK_LPAREN;
			")": pk = TK_RPAREN;
			"{": pk = TK_LBRACE;
			"}": pk = TK_RBRACE;
			"[": pk = TK_LBRACKET;
			"]": pk = TK_RBRACKET;
			";": pk = TK_SEMI;
			":": pk = TK_COLON;
			",": pk = TK_COMMA;
			".": pk = TK_DOT;
			"+", "-", "*", "%": pk = TK_BINOP;
			"/": lx_mode = M_SLASH;
			"!": lx_mode = M_BANG;
			"=": lx_mode = M_EQ;
			">": lx_mode = M_GT;
			"<": lx_mode = M_LT;
			default: ;
		endcase
		if (c == "\"") begin
			lx_mode = M_STRING;
			lx_start = sat_up(pos);
			lx_len = '0;
		end else if (pk != 6'd0) begin
			add_rec(RK_TOKEN, pk, pos, 20'd1, 8'd0);
		end else if (lx_mode != M_NORMAL) begin
			lx_start = pos;
			lx_len = 20'd1;
		end else if (digit_c(c)) begin
			lx_mode = M_NUMBER;
			lx_start = pos;
			lx_len = 20'd1;
		end else if (letter_c(c)) begin
			lx_mode = M_WORD;
			lx_start = pos;
			lx_len = 20'd1;
			lx_word = 64'(c);
			lx_long = 1'b0;
		end else if (!space_c(c)) begin
			add_rec(RK_BAD_CHAR, TK_IDENT, pos, 20'd1, c);
		end
	endtask

	task automatic lexer_reset();
		lx_mode = M_NORMAL;
		lx_star = 1'b0;
		lx_pos = '0;
		lx_start = '0;
		lx_len = '0;
		lx_word = '0;
		lx_long = 1'b0;
	endtask

	task automatic predict_tokens(logic k, logic [7:0] c);
		new_recs.delete();
		if (k == IN_END) begin
			if (lx_mode == M_STRING)
				add_rec(RK_OPEN_STRING, TK_STRING, lx_start, lx_len, 8'd0);
			else if (lx_mode != M_LINE && lx_mode != M_BLOCK) flush_token();
			add_rec(RK_TOKEN, TK_EOF, lx_pos, 20'd0, 8'd0);
			lexer_reset();
		end else begin
			case (lx_mode)
				M_STRING:
					if (c == "\"") begin
						add_rec(RK_TOKEN, TK_STRING, lx_start, lx_len, 8'd0);
						lx_mode = M_NORMAL;
					end else lx_len = sat_up(lx_len);
				M_LINE: if (c == 8'd10) lx_mode = M_NORMAL;
				M_BLOCK:
					if (lx_star && c == "/") begin
						lx_mode = M_NORMAL;
						lx_star = 1'b0;
					end else lx_star = (c == "*");
				M_NUMBER:
					if (digit_c(c)) lx_len = sat_up(lx_len);
					else begin
						flush_token();
						begin_char(c, lx_pos);
					end
				M_WORD:
					if (letter_c(c)) begin
						if (!lx_long && lx_len < KEYWORD_CHARS) lx_word = {lx_word[55:0], c};
						else lx_long = 1'b1;
						lx_len = sat_up(lx_len);
					end else begin
						flush_token();
						begin_char(c, lx_pos);
					end
				M_SLASH:
					if (c == "/") lx_mode = M_LINE;
					else if (c == "*") begin
						lx_mode = M_BLOCK;
						lx_star = 1'b0;
					end else begin
						flush_token();
						begin_char(c, lx_pos);
					end
				M_BANG, M_EQ, M_GT, M_LT:
					if (c == "=") begin
						add_rec(RK_TOKEN, TK_LOGICOP, lx_start, 20'd2, 8'd0);
						lx_mode = M_NORMAL;
					end else begin
						flush_token();
						begin_char(c, lx_pos);
					end
				default: begin_char(c, lx_pos);
			endcase
			lx_pos = sat_up(lx_pos);
		end
		if (new_recs.size() > 0) new_recs[new_recs.size()-1].lst = 1'b1;
		foreach (new_recs[i]) expected_tokens.insert(expected_tokens.size(), new_recs[i]);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_request(logic k, logic [7:0] c, bit gaps = 1);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		source_byte <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_tokens(k, c);
		bytes_sent++;
	endtask

	task automatic send_text(string s, bit gaps = 1);
		for (int i = 0; i < s.len(); i++) send_request(IN_BYTE, s[i], gaps);
	endtask

	// receiver
	always @(posedge clk) begin
		token_rec_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{record_kind, token_kind, start_offset, token_length, bad_char, last};
			records_seen++;
			if (expected_tokens.size() == 0) begin
				$error("unexpected record %p", got);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (got.rk !== want.rk) begin
					$error("record_kind exp %0d got %0d", want.rk, got.rk); fail_count++;
				end
				if (got.tk !== want.tk) begin
					$error("token_kind exp %0d got %0d", want.tk, got.tk); fail_count++;
				end
				if (got.st !== want.st) begin
					$error("start_offset exp %0d got %0d", want.st, got.st); fail_count++;
				end
				if (got.ln !== want.ln) begin
					$error("token_length exp %0d got %0d", want.ln, got.ln); fail_count++;
				end
				if (got.bc !== want.bc) begin
					$error("bad_char exp %0d got %0d", want.bc, got.bc); fail_count++;
				end
				if (got.lst !== want.lst) begin
					$error("last exp %0d got %0d", want.lst, got.lst); fail_count++;
				end
			end
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			stall = gap_len();
			if (stall > 0 && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic test_punctuation();
		send_text("(){}[];:,.+-*%/ ! = > < != == >= <= !a=b>1<x/y");
		send_request(IN_END, 8'h00);
	endtask

	task automatic test_keywords();
		send_text("let const print toggle split length read write exec spawn if else ");
		send_text("while for function return break continue functions lets iff ");
		send_text("continuex abcdefghij LET 0123 42x");
		send_request(IN_END, 8'h00);
	endtask

	task automatic test_comments_strings();
		send_text("a//line x\nb/* c **/d/*/ e */f\"str\"\"\"g/* open");
		send_request(IN_END, 8'h00);
		send_text("x \"unterminated");
		send_request(IN_END, 8'h00);
		send_text("word");
		send_request(IN_END, 8'h00);
		send_request(IN_END, 8'h00);
		send_request(IN_BYTE, 8'h00);
		send_request(IN_BYTE, 8'hFF);
		send_request(IN_BYTE, 8'h80);
		send_text("#@\t\015\f\v\n$");
		send_request(IN_END, 8'hFF);
	endtask

	function automatic logic [7:0] pick_char();
		string pool;
		int r;
		pool = "abcdefghijklmnopqrstuvwxyzABZ0123456789 \n\t\"/*!=<>(){}[];:,.+-%";
		r = $urandom_range(0, 99);
		if (r < 85) return pool[$urandom_range(0, pool.len() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_random_source();
		int sent;
		string kw;
		string kws[6] = '{"let ", "while(", "function ", "continue;", "print ", "if "};
		sent = 0;
		while (sent < 80) begin
			if ($urandom_range(0, 4) == 0) begin
				kw = kws[$urandom_range(0, 5)];
				send_text(kw);
				sent += kw.len();
			end else begin
				send_request(IN_BYTE, pick_char());
				sent++;
			end
			if ($urandom_range(0, 40) == 0) send_request(IN_END, 8'($urandom));
			if (sent > 30 && sent < 40) hold_off = 1'b1;
		end
		send_request(IN_END, 8'h00);
	endtask

	task automatic test_back_pressure();
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++) send_text("(", 0);
		send_request(IN_END, 8'h00, 0);
	endtask

	initial begin
		int drain;
		lexer_reset();
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		source_byte = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_punctuation();
		test_keywords();
		test_comments_strings();
		test_back_pressure();
		test_random_source();
		in_valid <= 1'b0;
		drain = 0;
		while (expected_tokens.size() > 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		$display("covered %0d input requests and %0d records: operators, keywords,",
			bytes_sent, records_seen);
		$display("comments, strings, bad bytes, end-of-source flushes and output stalls");
		if (fail_count == 0 && expected_tokens.size() == 0) begin
			$display("** script_token_lexer: PASSED **");
		end else begin
			$display("** script_token_lexer: FAILED **");
		end
		$finish;
	end

endmodule
